FILE: hw/rtl/lryt_pkg.sv
package lryt_pkg;

   localparam int NumRingsDefault = 32;
   localparam int CordicSteps = 16;
   localparam int HalfTurn = 46080;
   localparam int FullTurn = 92160;
   localparam int RevUs = 99723;
   localparam logic [23:0] TimeMax = 24'hFFFFFF;

   localparam logic [1:0] CSR_KEEP_EVERY = 2'd0;
   localparam logic [1:0] CSR_USE_GIVEN = 2'd1;
   localparam logic [1:0] CSR_TIME_GAIN = 2'd2;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic [7:0] level;
      logic [23:0] time_us;
   } point_out_type;

   function automatic logic [22:0] atan_entry(input logic [3:0] i);
      logic [22:0] v;
      begin
         unique case (i)
            4'd0: v = 23'd2949120;
            4'd1: v = 23'd1740967;
            4'd2: v = 23'd919879;
            4'd3: v = 23'd466945;
            4'd4: v = 23'd234379;
            4'd5: v = 23'd117304;
            4'd6: v = 23'd58666;
            4'd7: v = 23'd29335;
            4'd8: v = 23'd14668;
            4'd9: v = 23'd7334;
            4'd10: v = 23'd3667;
            4'd11: v = 23'd1833;
            4'd12: v = 23'd917;
            4'd13: v = 23'd458;
            4'd14: v = 23'd229;
            default: v = 23'd115;
         endcase
         return v;
      end
   endfunction

endpackage

FILE: hw/rtl/lryt_req_if.sv
interface lryt_req_if;
   logic valid;
   logic ready;
   logic frame_start;
   logic signed [23:0] x_pos;
   logic signed [23:0] y_pos;
   logic signed [23:0] z_pos;
   logic [7:0] ring_id;
   logic [7:0] echo_level;
   logic [31:0] raw_time;
   logic coord_invalid;
   modport source (output valid, frame_start, x_pos, y_pos, z_pos, ring_id, echo_level,
                   raw_time, coord_invalid, input ready);
   modport sink (input valid, frame_start, x_pos, y_pos, z_pos, ring_id, echo_level,
                 raw_time, coord_invalid, output ready);
endinterface

FILE: hw/rtl/lryt_rsp_if.sv
interface lryt_rsp_if;
   logic valid;
   logic ready;
   logic signed [23:0] out_x;
   logic signed [23:0] out_y;
   logic signed [23:0] out_z;
   logic [7:0] out_level;
   logic [23:0] offset_time_us;
   modport source (output valid, out_x, out_y, out_z, out_level, offset_time_us,
                   input ready);
   modport sink (input valid, out_x, out_y, out_z, out_level, offset_time_us,
                 output ready);
endinterface

FILE: hw/rtl/lidar_ring_yaw_timestamp_core.sv
// In given-time mode an accepted point goes through the gain and time states to a valid
// result; in azimuth mode it goes through the CORDIC, round, lag, out, scale, write and
// time states, and a ring-seeding point gives no result. A new point is taken only in
// idle, after the last one is through; a dropped point leaves the core idle. The 16-step
// CORDIC and the time scaling set the azimuth rate, and a stalled result holds the input off.
// Synchronous active-high reset restores the register defaults, clears the decimation
// counter and the ring marks; the yaw and time memories are not cleared.
module lidar_ring_yaw_timestamp_core
   import lryt_pkg::*;
#(
   parameter int NUM_RINGS = NumRingsDefault
) (
   input logic clock,
   input logic reset,
   lryt_req_if.sink req,
   lryt_rsp_if.source rsp,
   input logic csr_write_enable,
   input logic [1:0] csr_index,
   input logic [31:0] csr_write_data
);

   localparam int RW = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
   localparam logic [28:0] TimeRecip = 29'd380717323;

   typedef enum logic [3:0] {
      S_IDLE, S_GAIN, S_CORDIC, S_ROUND, S_LAG, S_TIME, S_WRITE, S_OUT, S_SCALE
   } state_type;

   state_type state_ff;
   logic [7:0] keep_every_ff;
   logic use_given_ff;
   logic [31:0] time_gain_ff;
   logic [7:0] decim_ff;
   logic [NUM_RINGS-1:0] seen_ff;

   logic signed [23:0] x_ff, y_ff, z_ff;
   logic [7:0] level_ff;
   logic [31:0] raw_ff;
   logic [RW-1:0] ring_ff;
   logic signed [35:0] cx_ff, cy_ff;
   logic signed [26:0] cz_ff;
   logic [3:0] step_ff;
   logic signed [17:0] yaw_ff;
   logic [17:0] lag_ff;
   logic [24:0] t_ff;
   logic [63:0] prod_ff;
   logic out_valid_ff;
   point_out_type out_ff;

   logic signed [16:0] first_mem [NUM_RINGS];
   logic [17:0] last_mem [NUM_RINGS];
   logic signed [16:0] first_rd_ff;
   logic [17:0] last_rd_ff;
   logic mem_we;
   logic signed [16:0] mem_first_wr;
   logic [17:0] mem_last_wr;

   logic [7:0] ke;
   logic keep;
   logic [8:0] decim_inc;
   logic [RW-1:0] req_ring;
   logic ring_ok;
   logic signed [35:0] dx, dy;
   logic signed [26:0] zr;
   logic signed [17:0] r_round;
   logic [17:0] lag_c;
   logic [28:0] lag_num;
   logic [57:0] recip_prod;
   logic [24:0] t_div;
   logic [24:0] t_adj;

   assign ke = (keep_every_ff == 8'd0) ? 8'd1 : keep_every_ff;
   assign req_ring = req.ring_id[RW-1:0];
   assign ring_ok = ({24'd0, req.ring_id} < 32'(NUM_RINGS));
   assign req.ready = (state_ff == S_IDLE) && !(out_valid_ff && !rsp.ready);
   assign decim_inc = (req.frame_start ? 9'd0 : {1'b0, decim_ff}) + 9'd1;
   assign keep = req.frame_start || (decim_ff == 8'd0);

   assign dx = cy_ff >>> step_ff;
   assign dy = cx_ff >>> step_ff;
   assign zr = (cz_ff + 27'sd128) >>> 8;
   always_comb begin
      r_round = zr[17:0];
      if (r_round > 18'sd46080) begin
         r_round = r_round - 18'sd92160;
      end else if (r_round <= -18'sd46080) begin
         r_round = r_round + 18'sd92160;
      end
   end
   always_comb begin
      if (yaw_ff <= 18'(signed'(first_rd_ff))) begin
         lag_c = 18'(18'(signed'(first_rd_ff)) - yaw_ff);
      end else begin
         lag_c = 18'(18'(signed'(first_rd_ff)) - yaw_ff + 18'sd92160);
      end
   end
   // The time is (lag * 3125 + 1444) / 2888, taken by a reciprocal multiply.
   assign lag_num = 29'(lag_ff) * 29'd3125 + 29'd1444;
   assign recip_prod = 58'(prod_ff[28:0]) * 58'(TimeRecip);
   assign t_div = {7'd0, recip_prod[57:40]};
   assign t_adj = (t_ff < 25'(last_rd_ff)) ? t_ff + 25'(RevUs) : t_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         first_mem[ring_ff] <= mem_first_wr;
         last_mem[ring_ff] <= mem_last_wr;
      end
      first_rd_ff <= first_mem[ring_ff];
      last_rd_ff <= last_mem[ring_ff];
   end

   always_comb begin
      mem_we = 1'b0;
      mem_first_wr = yaw_ff[16:0];
      mem_last_wr = 18'd0;
      if (state_ff == S_LAG && !seen_ff[ring_ff]) begin
         mem_we = 1'b1;
      end else if (state_ff == S_WRITE) begin
         mem_we = 1'b1;
         mem_first_wr = first_rd_ff;
         mem_last_wr = t_adj[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         keep_every_ff <= 8'd1;
         use_given_ff <= 1'b1;
         time_gain_ff <= 32'd65536;
         decim_ff <= 8'd0;
         seen_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_KEEP_EVERY: keep_every_ff <= csr_write_data[7:0];
               CSR_USE_GIVEN: use_given_ff <= csr_write_data[0];
               CSR_TIME_GAIN: time_gain_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (out_valid_ff && rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  decim_ff <= (decim_inc >= {1'b0, ke}) ? 8'd0 : decim_inc[7:0];
                  if (req.frame_start) begin
                     seen_ff <= '0;
                  end
                  x_ff <= req.x_pos;
                  y_ff <= req.y_pos;
                  z_ff <= req.z_pos;
                  level_ff <= req.echo_level;
                  raw_ff <= req.raw_time;
                  ring_ff <= req_ring;
                  step_ff <= 4'd0;
                  if (req.x_pos < 0) begin
                     cx_ff <= -(36'(req.x_pos) <<< 8);
                     cy_ff <= -(36'(req.y_pos) <<< 8);
                     cz_ff <= (req.y_pos >= 0) ? 27'sd11796480 : -27'sd11796480;
                  end else begin
                     cx_ff <= 36'(req.x_pos) <<< 8;
                     cy_ff <= 36'(req.y_pos) <<< 8;
                     cz_ff <= '0;
                  end
                  if (keep && !req.coord_invalid && ring_ok) begin
                     state_ff <= use_given_ff ? S_GAIN : S_CORDIC;
                  end
               end
            end
            S_GAIN: begin
               prod_ff <= 64'(raw_ff) * 64'(time_gain_ff);
               state_ff <= S_TIME;
            end
            S_CORDIC: begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + dx;
                  cy_ff <= cy_ff - dy;
                  cz_ff <= cz_ff + 27'(atan_entry(step_ff));
               end else begin
                  cx_ff <= cx_ff - dx;
                  cy_ff <= cy_ff + dy;
                  cz_ff <= cz_ff - 27'(atan_entry(step_ff));
               end
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'(CordicSteps - 1)) begin
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               if (x_ff == 0 && y_ff == 0) begin
                  yaw_ff <= '0;
               end else begin
                  yaw_ff <= r_round;
               end
               state_ff <= S_LAG;
            end
            S_LAG: begin
               if (!seen_ff[ring_ff]) begin
                  seen_ff[ring_ff] <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  lag_ff <= lag_c;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               prod_ff <= {35'd0, lag_num};
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               state_ff <= S_TIME;
            end
            S_TIME: begin
               out_valid_ff <= 1'b1;
               out_ff.x <= x_ff;
               out_ff.y <= y_ff;
               out_ff.z <= z_ff;
               out_ff.level <= level_ff;
               if (use_given_ff) begin
                  out_ff.time_us <= (prod_ff[63:40] != 24'd0) ? TimeMax : prod_ff[39:16];
               end else begin
                  out_ff.time_us <= t_ff[24] ? TimeMax : t_ff[23:0];
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SCALE) begin
         t_ff <= t_div;
      end else if (state_ff == S_WRITE) begin
         t_ff <= t_adj;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.out_x = out_ff.x;
   assign rsp.out_y = out_ff.y;
   assign rsp.out_z = out_ff.z;
   assign rsp.out_level = out_ff.level;
   assign rsp.offset_time_us = out_ff.time_us;

`ifndef NO_ASSERTIONS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(out_ff))
      else $error("stalled result changed");
   a_cordic_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |-> $past(state_ff) == S_CORDIC && step_ff == 4'd0)
      else $error("cordic step count wrong");
`endif

endmodule

FILE: bench/lryt_point_checker.sv
`timescale 1ns / 100ps

module lryt_point_checker
   import lryt_pkg::*;
(
   input logic clock,
   input logic reset,
   lryt_req_if.sink req,
   lryt_rsp_if.sink rsp,
   input logic csr_write_enable,
   input logic [1:0] csr_index,
   input logic [31:0] csr_write_data,
   output int fail_count,
   output int points_pending
);

   localparam int NumRings = NumRingsDefault;

   logic [7:0] keep_every;
   logic use_given;
   logic [31:0] time_gain;
   logic ring_seen [NumRings];
   logic signed [16:0] ring_first_yaw [NumRings];
   logic [17:0] ring_last_time [NumRings];
   logic [7:0] decim_count;
   point_out_type expected_points [$];

   assign points_pending = expected_points.size();

   function automatic longint floor_shift(input longint v, input int k);
      if (v >= 0) begin
         return v >>> k;
      end
      return -(((-v) - 1) >>> k) - 1;
   endfunction

   function automatic longint yaw_of(input longint x, input longint y);
      longint cx, cy, z, dx, dy, r;
      cx = x * 256;
      cy = y * 256;
      z = 0;
      if (x == 0 && y == 0) begin
         return 0;
      end
      if (x < 0) begin
         cx = -cx;
         cy = -cy;
         z = (y >= 0 ? HalfTurn : -HalfTurn) * 256;
      end
      for (int i = 0; i < CordicSteps; i++) begin
         dx = floor_shift(cy, i);
         dy = floor_shift(cx, i);
         if (cy > 0) begin
            cx += dx;
            cy -= dy;
            z += longint'(atan_entry(i[3:0]));
         end else begin
            cx -= dx;
            cy += dy;
            z -= longint'(atan_entry(i[3:0]));
         end
      end
      r = floor_shift(z + 128, 8);
      if (r > HalfTurn) r -= FullTurn;
      if (r <= -HalfTurn) r += FullTurn;
      return r;
   endfunction

   task automatic predict_point();
      logic [7:0] step;
      logic keep;
      int ring;
      longint yaw, first, lag;
      longint unsigned t;
      point_out_type p;
      step = (keep_every == 0) ? 8'd1 : keep_every;
      ring = req.ring_id;
      if (req.frame_start) begin
         foreach (ring_seen[i]) ring_seen[i] = 1'b0;
         decim_count = 8'd0;
      end
      keep = (decim_count == 0);
      decim_count = (int'(decim_count) + 1 >= int'(step)) ? 8'd0 : decim_count + 8'd1;
      if (!keep || req.coord_invalid || ring >= NumRings) begin
         return;
      end
      if (use_given) begin
         t = (longint'(req.raw_time) * longint'(time_gain)) >> 16;
      end else begin
         yaw = yaw_of(req.x_pos, req.y_pos);
         if (!ring_seen[ring]) begin
            ring_seen[ring] = 1'b1;
            ring_first_yaw[ring] = 17'(yaw);
            ring_last_time[ring] = 18'd0;
            return;
         end
         first = ring_first_yaw[ring];
         lag = (yaw <= first) ? first - yaw : first - yaw + FullTurn;
         t = (lag * 100000 + 46208) / 92416;
         if (t < ring_last_time[ring]) t += RevUs;
         ring_last_time[ring] = t[17:0];
      end
      if (t > TimeMax) t = TimeMax;
      p.x = req.x_pos;
      p.y = req.y_pos;
      p.z = req.z_pos;
      p.level = req.echo_level;
      p.time_us = t[23:0];
      expected_points = {expected_points, p};
   endtask

   always @(posedge clock) begin
      point_out_type e;
      if (reset) begin
         keep_every <= 8'd1;
         use_given <= 1'b1;
         time_gain <= 32'd65536;
         decim_count = 8'd0;
         foreach (ring_seen[i]) ring_seen[i] = 1'b0;
         fail_count = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_KEEP_EVERY: keep_every <= csr_write_data[7:0];
               CSR_USE_GIVEN: use_given <= csr_write_data[0];
               CSR_TIME_GAIN: time_gain <= csr_write_data;
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            predict_point();
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t unexpected point x=%0d", $time, rsp.out_x);
               fail_count++;
            end else begin
               e = expected_points.pop_front();
               if (e.x !== rsp.out_x || e.y !== rsp.out_y || e.z !== rsp.out_z
                   || e.level !== rsp.out_level || e.time_us !== rsp.offset_time_us) begin
                  $display("%0t mismatch expected %0d %0d %0d %0d %0d actual %0d %0d %0d %0d %0d",
                     $time, e.x, e.y, e.z, e.level, e.time_us, rsp.out_x, rsp.out_y,
                     rsp.out_z, rsp.out_level, rsp.offset_time_us);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench
   import lryt_pkg::*;
();

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [1:0] csr_index;
   logic [31:0] csr_write_data;
   int fail_count;
   int points_pending;
   int send_idle_pct;
   int stall_pct;
   bit long_hold;

   lryt_req_if req ();
   lryt_rsp_if rsp ();

   lidar_ring_yaw_timestamp_core i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   lryt_point_checker i_checker (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.sink),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .fail_count(fail_count),
      .points_pending(points_pending)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("status: fail");
      $finish;
   end

   initial begin
      rsp.ready = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp.ready <= 0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic drain_points();
      req.valid <= 0;
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic send_point(input logic fs, input logic signed [23:0] x,
                             input logic signed [23:0] y, input logic [7:0] ring,
                             input logic [31:0] raw, input logic bad);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      req.frame_start <= fs;
      req.x_pos <= x;
      req.y_pos <= y;
      req.z_pos <= 24'($urandom);
      req.ring_id <= ring;
      req.echo_level <= 8'($urandom);
      req.raw_time <= raw;
      req.coord_invalid <= bad;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic random_point(input int frame_pct);
      int kind;
      logic [7:0] ring;
      logic signed [23:0] x, y;
      kind = $urandom_range(99);
      ring = (kind < 90) ? 8'($urandom_range(NumRingsDefault - 1)) : 8'($urandom);
      x = 24'($urandom);
      y = 24'($urandom);
      if (kind < 40) begin
         x = 24'($signed(24'($urandom_range(4000))) - 2000);
         y = 24'($signed(24'($urandom_range(4000))) - 2000);
      end
      send_point($urandom_range(99) < frame_pct, x, y, ring, $urandom,
                 $urandom_range(99) < 5);
   endtask

   initial begin
      logic signed [23:0] ex [6];
      reset = 1;
      csr_write_enable = 0;
      csr_index = CSR_KEEP_EVERY;
      csr_write_data = 0;
      req.valid = 0;
      req.frame_start = 0;
      req.x_pos = 0;
      req.y_pos = 0;
      req.z_pos = 0;
      req.ring_id = 0;
      req.echo_level = 0;
      req.raw_time = 0;
      req.coord_invalid = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      long_hold = 0;
      ex = '{24'sh7FFFFF, -24'sh800000, 24'sd0, 24'sd1, -24'sd1, 24'sd1000};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_point(1'b1, 24'sd5, 24'sd5, 8'd0, 32'hFFFFFFFF, 1'b0);
      send_point(1'b0, 24'sd5, 24'sd5, 8'd1, 32'd0, 1'b0);
      send_point(1'b0, 24'sd5, 24'sd5, 8'd2, 32'd5, 1'b1);
      send_point(1'b0, 24'sd5, 24'sd5, 8'd200, 32'd5, 1'b0);
      drain_points();
      write_csr(CSR_TIME_GAIN, 32'hFFFFFFFF);
      send_point(1'b0, 24'sd1, 24'sd1, 8'd3, 32'hFFFFFFFF, 1'b0);
      send_point(1'b0, 24'sd1, 24'sd1, 8'd3, 32'h12345, 1'b0);
      drain_points();
      write_csr(CSR_USE_GIVEN, 32'd0);
      write_csr(CSR_TIME_GAIN, 32'd0);
      send_point(1'b1, 24'sd0, 24'sd0, 8'd0, 32'd0, 1'b0);
      foreach (ex[i]) begin
         foreach (ex[j]) send_point(1'b0, ex[i], ex[j], 8'd0, 32'd0, 1'b0);
      end
      send_point(1'b0, 24'sd5, 24'sd5, 8'd255, 32'd0, 1'b0);
      drain_points();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 80; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 80; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         write_csr(CSR_USE_GIVEN, 32'(ph % 2));
         write_csr(CSR_KEEP_EVERY,
                   32'((ph == 3) ? 8'd255 : (ph == 5) ? 8'd0 : 8'($urandom_range(3))));
         write_csr(CSR_TIME_GAIN, (ph == 7) ? 32'd0 : $urandom);
         if (ph == 0) long_hold = 1;
         for (int n = 0; n < 215; n++) random_point(ph == 3 ? 0 : 3);
         drain_points();
      end
      drain_points();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/lryt_pkg.sv
hw/rtl/lryt_req_if.sv
hw/rtl/lryt_rsp_if.sv
hw/rtl/lidar_ring_yaw_timestamp_core.sv
bench/lryt_point_checker.sv
bench/testbench.sv
